// ===== hdl/rcs_pkg.sv =====
package rcs_pkg;

    localparam int STORE_DEPTH = 4096;
    localparam int ADDR_W      = 12;
    localparam int COS_DEPTH   = 1024;
    localparam int COS_W       = 16;
    localparam int DIST_W      = 24;
    localparam int HEIGHT_W    = 24;
    localparam int NUM_W       = 35;
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 32;

    localparam logic [HEIGHT_W-1:0] HEIGHT_MAX = '1;

    localparam logic [15:0] PPD_RESET     = 16'd693;
    localparam logic [10:0] TILE_RESET    = 11'd64;
    localparam logic [11:0] SCREEN_RESET  = 12'd600;
    localparam logic [31:0] CEILING_RESET = 32'hFF33_3333;
    localparam logic [31:0] FLOOR_RESET   = 32'hFF77_7777;

    localparam logic KIND_LOAD  = 1'b0;
    localparam logic KIND_SHADE = 1'b1;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_PROJ_PLANE_DIST = 3'd0,
        CFG_TILE_SIZE       = 3'd1,
        CFG_SCREEN_HEIGHT   = 3'd2,
        CFG_CEILING_COLOR   = 3'd3,
        CFG_FLOOR_COLOR     = 3'd4
    } t_cfg_idx;

    typedef enum logic [1:0] {
        REG_CEILING = 2'd0,
        REG_WALL    = 2'd1,
        REG_FLOOR   = 2'd2
    } t_region;

    typedef struct packed {
        logic               kind;
        logic [11:0]        texel_index;
        logic [31:0]        texel_value;
        logic [23:0]        ray_distance;
        logic signed [11:0] angle_offset;
        logic               hit_vertical;
        logic [15:0]        hit_x;
        logic [15:0]        hit_y;
        logic [10:0]        row;
    } t_in_item;

    typedef struct packed {
        logic [31:0] pixel_color;
        logic [1:0]  region;
    } t_out_item;

    typedef logic [COS_W-1:0] t_cos_rom [COS_DEPTH];

    localparam longint Q30_ONE = 64'sd1 << 30;
    localparam longint PI_Q30  = 64'sd3373259426;

    // Taylor series of cos(k/4096 turn) in Q30, evaluated Horner style.
    function automatic logic [COS_W-1:0] cos_entry(input int unsigned k);
        longint x;
        longint x2;
        longint t;
        x  = (longint'(k) * PI_Q30) / 2048;
        x2 = (x * x) >>> 30;
        t  = Q30_ONE;
        t  = Q30_ONE - ((x2 * t) >>> 30) / 132;
        if (t < 0) t = 0;
        t  = Q30_ONE - ((x2 * t) >>> 30) / 90;
        if (t < 0) t = 0;
        t  = Q30_ONE - ((x2 * t) >>> 30) / 56;
        if (t < 0) t = 0;
        t  = Q30_ONE - ((x2 * t) >>> 30) / 30;
        if (t < 0) t = 0;
        t  = Q30_ONE - ((x2 * t) >>> 30) / 12;
        if (t < 0) t = 0;
        t  = Q30_ONE - ((x2 * t) >>> 30) / 2;
        if (t < 0) t = 0;
        return COS_W'((t + (64'sd1 <<< 14)) >>> 15);
    endfunction

    function automatic t_cos_rom cos_rom();
        t_cos_rom r;
        for (int k = 0; k < COS_DEPTH; k++) begin
            r[k] = cos_entry(k);
        end
        return r;
    endfunction

endpackage

// ===== hdl/rcs_div.sv =====
module rcs_div #(
    parameter int NW = 35,
    parameter int DW = 24,
    parameter int QW = 24,
    parameter int SW = 1
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_en,
    input  logic          i_valid,
    input  logic [NW-1:0] i_num,
    input  logic [DW-1:0] i_den,
    input  logic [SW-1:0] i_side,
    output logic          o_valid,
    output logic [QW-1:0] o_quo,
    output logic [SW-1:0] o_side
);

    // Restoring division, one quotient bit per stage, most significant first.
    // The quotient is expected to fit in QW bits.
    localparam int W = (NW > DW + QW) ? NW : DW + QW;

    logic [W-1:0]  r_rem  [1:QW];
    logic [DW-1:0] r_den  [1:QW];
    logic [QW-1:0] r_quo  [1:QW];
    logic [SW-1:0] r_side [1:QW];
    logic          r_vld  [1:QW];

    for (genvar k = 0; k < QW; k++) begin : g_step
        localparam int B = QW - 1 - k;
        logic [W-1:0]  w_rem;
        logic [DW-1:0] w_den;
        logic [QW-1:0] w_quo;
        logic [SW-1:0] w_side;
        logic          w_vld;
        logic [W-1:0]  w_sub;
        logic          w_ge;

        if (k == 0) begin : g_first
            assign w_rem  = W'(i_num);
            assign w_den  = i_den;
            assign w_quo  = '0;
            assign w_side = i_side;
            assign w_vld  = i_valid;
        end else begin : g_next
            assign w_rem  = r_rem[k];
            assign w_den  = r_den[k];
            assign w_quo  = r_quo[k];
            assign w_side = r_side[k];
            assign w_vld  = r_vld[k];
        end

        assign w_sub = W'(w_den) << B;
        assign w_ge  = (w_rem >= w_sub);

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[k+1]  <= w_ge ? (w_rem - w_sub) : w_rem;
                r_quo[k+1]  <= w_ge ? (w_quo | (QW'(1) << B)) : w_quo;
                r_den[k+1]  <= w_den;
                r_side[k+1] <= w_side;
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[k+1] <= 1'b0;
            end else if (i_en) begin
                r_vld[k+1] <= w_vld;
            end
        end
    end

    assign o_valid = r_vld[QW];
    assign o_quo   = r_quo[QW];
    assign o_side  = r_side[QW];

endmodule

// ===== hdl/raycast_column_shader.sv =====
// Raycast column shader: one item per clock in each direction. A shade
// transaction yields one pixel; a load transaction writes one texel and
// yields nothing. Each passes the capture stage, stage 1, the 24-bit strip
// height divider, the region stage, the texture row divider and the store
// stage, the two dividers being bit-per-stage pipelines, and the whole
// pipeline halts only while a finished pixel waits on a stalled output. The
// cosine table is a registered ROM read as the transaction is accepted; the
// 4096-entry texture store is a single-port memory with no clearing pass, so
// entries read before they are loaded return undefined data.
module raycast_column_shader #(
    parameter int TEX_SIZE = 64,
    parameter int MAX_ROWS = 2048
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_valid,
    input  rcs_pkg::t_in_item                  i_in,
    output logic                               o_stall,
    output logic                               o_valid,
    output rcs_pkg::t_out_item                 o_out,
    input  logic                               i_stall,
    input  logic                               i_cfg_we,
    input  logic [rcs_pkg::CFG_IDX_W-1:0]      i_cfg_idx,
    input  logic [rcs_pkg::CFG_DATA_W-1:0]     i_cfg_wdata
);
    import rcs_pkg::*;

    localparam int TSW = $clog2(TEX_SIZE + 1);
    localparam int XW  = $clog2(TEX_SIZE);
    localparam int NW2 = HEIGHT_W + TSW;

    // Texture column by reciprocal multiplication, exact for 16-bit coordinates.
    localparam int     COL_SH    = 16 + XW;
    localparam longint COL_RECIP = ((64'sd1 <<< COL_SH) + TEX_SIZE - 1) / TEX_SIZE;

    localparam t_cos_rom COS_ROM = cos_rom();

    typedef struct packed {
        logic          kind;
        logic [11:0]   texel_index;
        logic [31:0]   texel_value;
        logic [10:0]   row;
        logic          ovf;
        logic [XW-1:0] tex_x;
    } t_side1;

    typedef struct packed {
        logic          kind;
        logic [11:0]   texel_index;
        logic [31:0]   texel_value;
        t_region       region;
        logic [XW-1:0] tex_x;
    } t_side2;

    // Configuration registers.
    logic [15:0] r_ppd;
    logic [10:0] r_tile;
    logic [11:0] r_screen;
    logic [31:0] r_ceiling;
    logic [31:0] r_floor;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ppd     <= PPD_RESET;
            r_tile    <= TILE_RESET;
            r_screen  <= SCREEN_RESET;
            r_ceiling <= CEILING_RESET;
            r_floor   <= FLOOR_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_PROJ_PLANE_DIST: r_ppd     <= i_cfg_wdata[15:0];
                CFG_TILE_SIZE:       r_tile    <= i_cfg_wdata[10:0];
                CFG_SCREEN_HEIGHT:   r_screen  <= i_cfg_wdata[11:0];
                CFG_CEILING_COLOR:   r_ceiling <= i_cfg_wdata;
                CFG_FLOOR_COLOR:     r_floor   <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    logic r_out_valid;
    logic w_en;

    assign w_en    = !r_out_valid || !i_stall;
    assign o_stall = !w_en;

    // Stage 0: capture the transaction and read the cosine ROM.
    logic [11:0]      w_mag;
    t_in_item         r0_item;
    logic [COS_W-1:0] r0_cos;
    logic             r0_cos_zero;
    logic             r0_valid;

    assign w_mag = i_in.angle_offset[11] ? (12'd0 - i_in.angle_offset) : i_in.angle_offset;

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r0_item     <= i_in;
            r0_cos      <= COS_ROM[w_mag[9:0]];
            r0_cos_zero <= (w_mag[11:10] != 2'd0);
        end
    end

    // Stage 1: perpendicular distance, the height numerator and the texture
    // column quotient.
    logic [COS_W-1:0]   w_cos;
    logic [39:0]        w_perp_full;
    logic [15:0]        w_coord0;
    logic [47:0]        w_col_prod;
    t_in_item           r1_item;
    logic [DIST_W-1:0]  r1_perp;
    logic [NUM_W-1:0]   r1_num;
    logic [15:0]        r1_col_q;
    logic               r1_valid;

    assign w_cos       = r0_cos_zero ? '0 : r0_cos;
    assign w_perp_full = 40'(r0_item.ray_distance) * 40'(w_cos);
    assign w_coord0    = r0_item.hit_vertical ? r0_item.hit_y : r0_item.hit_x;
    assign w_col_prod  = 48'(w_coord0) * 48'(COL_RECIP);

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r1_item  <= r0_item;
            r1_perp  <= w_perp_full[38:15];
            r1_num   <= NUM_W'(27'(r_tile) * 27'(r_ppd)) << 8;
            r1_col_q <= w_col_prod[COL_SH +: 16];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r0_valid <= 1'b0;
            r1_valid <= 1'b0;
        end else if (w_en) begin
            r0_valid <= i_valid;
            r1_valid <= r0_valid;
        end
    end

    // A zero distance or a quotient of 2^24 or more saturates the height.
    t_side1      w_side1;
    logic [15:0] w_coord;
    logic [15:0] w_col_rem;

    assign w_coord   = r1_item.hit_vertical ? r1_item.hit_y : r1_item.hit_x;
    assign w_col_rem = w_coord - 16'(24'(r1_col_q) * 24'(TEX_SIZE));

    assign w_side1.kind        = r1_item.kind;
    assign w_side1.texel_index = r1_item.texel_index;
    assign w_side1.texel_value = r1_item.texel_value;
    assign w_side1.row         = r1_item.row;
    assign w_side1.ovf         = (r1_perp == '0) ||
                                 (48'(r1_num) >= {r1_perp, 24'd0});
    assign w_side1.tex_x       = w_col_rem[XW-1:0];

    logic                d1_valid;
    logic [HEIGHT_W-1:0] d1_quo;
    t_side1              d1_side;

    rcs_div #(
        .NW (NUM_W),
        .DW (DIST_W),
        .QW (HEIGHT_W),
        .SW ($bits(t_side1))
    ) u_height_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (r1_valid),
        .i_num   (r1_num),
        .i_den   (r1_perp),
        .i_side  (w_side1),
        .o_valid (d1_valid),
        .o_quo   (d1_quo),
        .o_side  (d1_side)
    );

    // Region stage: clamp the strip to the screen and classify the row.
    logic [HEIGHT_W-1:0] w_height;
    logic [HEIGHT_W-2:0] w_half;
    logic [12:0]         w_hscr;
    logic [11:0]         w_mid;
    logic [24:0]         w_row_half;
    logic [24:0]         w_bottom;
    logic                w_ceiling;
    logic                w_wall;
    logic [HEIGHT_W-1:0] w_from_top;
    t_side2              w_side2;

    assign w_height   = d1_side.ovf ? HEIGHT_MAX : d1_quo;
    assign w_half     = w_height[HEIGHT_W-1:1];
    assign w_hscr     = ({1'b0, r_screen} > 13'(MAX_ROWS)) ? 13'(MAX_ROWS) : {1'b0, r_screen};
    assign w_mid      = w_hscr[12:1];
    assign w_row_half = 25'(d1_side.row) + 25'(w_half);
    assign w_bottom   = 25'(w_mid) + 25'(w_half);
    assign w_ceiling  = (w_row_half < 25'(w_mid));
    assign w_wall     = !w_ceiling && (25'(d1_side.row) < w_bottom) &&
                        (13'(d1_side.row) < w_hscr);
    assign w_from_top = HEIGHT_W'(w_row_half - 25'(w_mid));

    assign w_side2.kind        = d1_side.kind;
    assign w_side2.texel_index = d1_side.texel_index;
    assign w_side2.texel_value = d1_side.texel_value;
    assign w_side2.region      = w_ceiling ? REG_CEILING : (w_wall ? REG_WALL : REG_FLOOR);
    assign w_side2.tex_x       = d1_side.tex_x;

    t_side2              r2_side;
    logic [NW2-1:0]      r2_num;
    logic [HEIGHT_W-1:0] r2_height;
    logic                r2_valid;

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r2_side   <= w_side2;
            r2_num    <= NW2'(w_from_top) * NW2'(TEX_SIZE);
            r2_height <= w_height;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r2_valid <= 1'b0;
        end else if (w_en) begin
            r2_valid <= d1_valid;
        end
    end

    // Texture row: from_top * TEX_SIZE / height, below TEX_SIZE for wall rows.
    logic          d2_valid;
    logic [XW-1:0] d2_quo;
    t_side2        d2_side;

    rcs_div #(
        .NW (NW2),
        .DW (HEIGHT_W),
        .QW (XW),
        .SW ($bits(t_side2))
    ) u_row_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (r2_valid),
        .i_num   (r2_num),
        .i_den   (r2_height),
        .i_side  (r2_side),
        .o_valid (d2_valid),
        .o_quo   (d2_quo),
        .o_side  (d2_side)
    );

    // Texture store access. Loads and reads share one port in stream order,
    // so a texel read always sees every load accepted ahead of it.
    logic [31:0]       w_addr_full;
    logic [ADDR_W-1:0] w_addr;
    logic [31:0]       r_tex [STORE_DEPTH];
    logic [31:0]       r_rd_data;
    logic [31:0]       r_color;
    t_region           r_region;

    assign w_addr_full = 32'(TEX_SIZE) * 32'(d2_quo) + 32'(d2_side.tex_x);
    assign w_addr      = w_addr_full[ADDR_W-1:0];

    always_ff @(posedge i_clk) begin
        if (w_en && d2_valid) begin
            if (d2_side.kind == KIND_LOAD) begin
                r_tex[d2_side.texel_index] <= d2_side.texel_value;
            end else begin
                r_rd_data <= r_tex[w_addr];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_region <= d2_side.region;
            r_color  <= (d2_side.region == REG_CEILING) ? r_ceiling : r_floor;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_en) begin
            r_out_valid <= d2_valid && (d2_side.kind == KIND_SHADE);
        end
    end

    assign o_valid           = r_out_valid;
    assign o_out.pixel_color = (r_region == REG_WALL) ? r_rd_data : r_color;
    assign o_out.region      = r_region;

    a_load_no_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_en && d2_valid && d2_side.kind == KIND_LOAD) |=> !o_valid)
        else $error("load transaction produced a pixel");

    a_region_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_out.region != 2'd3))
        else $error("pixel with an undefined region code");

    a_wall_needs_height: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r2_valid && r2_side.kind == KIND_SHADE && r2_side.region == REG_WALL)
        |-> (r2_height >= HEIGHT_W'(2)))
        else $error("wall row classified with a strip shorter than two rows");

endmodule

// ===== tb/raycast_column_shader_checker.sv =====
`timescale 1ns / 100ps

module raycast_column_shader_checker
    import rcs_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    input  t_in_item              i_in,
    input  logic                  i_in_stall,
    input  logic                  i_out_valid,
    input  t_out_item             i_out,
    input  logic                  i_out_stall,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_wdata,
    output int                    o_errors,
    output int                    o_pending,
    output int                    o_checked
);

    localparam int TEX = 64;
    localparam int ROWS_MAX = 2048;

    logic [15:0] plane_dist;
    logic [10:0] tile;
    logic [11:0] scr_rows;
    logic [31:0] ceil_argb;
    logic [31:0] floor_argb;
    logic [31:0] texels [STORE_DEPTH];
    logic [15:0] cos_q15 [COS_DEPTH];
    t_out_item   pixel_q[$];

    // Quarter-wave cosine in Q1.15, from a nested Taylor series in Q30.
    function automatic logic [15:0] cosine_of(input int k);
        longint divs [6];
        longint x;
        longint x2;
        longint t;
        divs = '{132, 90, 56, 30, 12, 2};
        x  = (longint'(k) * 64'sd3373259426) / 2048;
        x2 = (x * x) >>> 30;
        t  = 64'sd1 << 30;
        for (int i = 0; i < 6; i++) begin
            t = (64'sd1 << 30) - ((x2 * t) >>> 30) / divs[i];
            if (t < 0) t = 0;
        end
        return 16'((t + (64'sd1 << 14)) >>> 15);
    endfunction

    function automatic t_out_item shade_pixel(input t_in_item it);
        t_out_item   px;
        logic [11:0] raw;
        int          mag;
        longint      cosv;
        longint      perp;
        longint      num;
        longint      height;
        longint      rows;
        longint      half;
        longint      mid;
        longint      top;
        longint      bottom;
        longint      row;
        longint      tex_x;
        longint      tex_y;
        raw  = it.angle_offset;
        mag  = raw[11] ? 4096 - int'(raw) : int'(raw);
        cosv = (mag < COS_DEPTH) ? longint'(cos_q15[mag]) : 0;
        perp = (longint'(it.ray_distance) * cosv) >>> 15;
        num  = longint'(tile) * longint'(plane_dist) * 256;
        if (perp == 0) begin
            height = 64'hFF_FFFF;
        end else begin
            height = num / perp;
            if (height > 64'hFF_FFFF) height = 64'hFF_FFFF;
        end
        rows   = (scr_rows > ROWS_MAX) ? ROWS_MAX : longint'(scr_rows);
        half   = height / 2;
        mid    = rows / 2;
        top    = (mid - half < 0) ? 0 : mid - half;
        bottom = (mid + half > rows) ? rows : mid + half;
        row    = longint'(it.row);
        if (row < top) begin
            px.pixel_color = ceil_argb;
            px.region      = REG_CEILING;
        end else if (row < bottom) begin
            tex_x = longint'(it.hit_vertical ? it.hit_y : it.hit_x) % TEX;
            tex_y = ((row + half - mid) * TEX) / height;
            px.pixel_color = texels[(TEX * tex_y + tex_x) % STORE_DEPTH];
            px.region      = REG_WALL;
        end else begin
            px.pixel_color = floor_argb;
            px.region      = REG_FLOOR;
        end
        return px;
    endfunction

    initial begin
        for (int k = 0; k < COS_DEPTH; k++) cos_q15[k] = cosine_of(k);
    end

    assign o_pending = pixel_q.size();

    always @(posedge i_clk) begin
        t_out_item want;
        if (!i_rst_n) begin
            plane_dist = PPD_RESET;
            tile       = TILE_RESET;
            scr_rows   = SCREEN_RESET;
            ceil_argb  = CEILING_RESET;
            floor_argb = FLOOR_RESET;
            pixel_q.delete();
            o_errors  = 0;
            o_checked = 0;
        end else begin
            if (i_cfg_we) begin
                case (t_cfg_idx'(i_cfg_idx))
                    CFG_PROJ_PLANE_DIST: plane_dist = i_cfg_wdata[15:0];
                    CFG_TILE_SIZE:       tile       = i_cfg_wdata[10:0];
                    CFG_SCREEN_HEIGHT:   scr_rows   = i_cfg_wdata[11:0];
                    CFG_CEILING_COLOR:   ceil_argb  = i_cfg_wdata;
                    CFG_FLOOR_COLOR:     floor_argb = i_cfg_wdata;
                    default: ;
                endcase
            end
            // The new transaction is queued before the output is checked so
            // that even a result emitted in the same cycle as its transaction would find its expectation.
            if (i_valid && !i_in_stall) begin
                if (i_in.kind == KIND_LOAD) begin
                    texels[i_in.texel_index] = i_in.texel_value;
                end else begin
                    pixel_q.push_back(shade_pixel(i_in));
                end
            end
            if (i_out_valid && !i_out_stall) begin
                if (pixel_q.size() == 0) begin
                    $display("%0t: unexpected pixel, actual color %h region %0d",
                             $time, i_out.pixel_color, i_out.region);
                    o_errors++;
                end else begin
                    want = pixel_q.pop_front();
                    o_checked++;
                    if (want.pixel_color !== i_out.pixel_color) begin
                        $display("%0t: pixel_color expected %h actual %h",
                                 $time, want.pixel_color, i_out.pixel_color);
                        o_errors++;
                    end
                    if (want.region !== i_out.region) begin
                        $display("%0t: region expected %0d actual %0d",
                                 $time, want.region, i_out.region);
                        o_errors++;
                    end
                end
            end
        end
    end

endmodule

// ===== tb/raycast_column_shader_tb.sv =====
`timescale 1ns / 100ps

module raycast_column_shader_tb;
    import rcs_pkg::*;

    localparam int DRAIN_CYCLES = 40;
    localparam int IDLE_LIMIT   = 2000;
    localparam int ITEMS_PER_SETTING = 230;
    localparam int FILL_TEXELS  = 512;

    logic                  clk;
    logic                  rst_n;
    logic                  in_valid;
    t_in_item              in_data;
    logic                  in_stall;
    logic                  out_valid;
    t_out_item             out_data;
    logic                  out_stall;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_idx;
    logic [CFG_DATA_W-1:0] cfg_wdata;
    logic                  in_acc;
    logic                  out_acc;
    logic                  idle_mode;
    int                    out_wait;
    int                    errors;
    int                    pending;
    int                    checked;
    int                    quiet_cycles;
    int                    shades;
    int                    loads;
    int                    cfg_writes;
    logic [11:0]           cur_rows;

    raycast_column_shader dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_valid     (in_valid),
        .i_in        (in_data),
        .o_stall     (in_stall),
        .o_valid     (out_valid),
        .o_out       (out_data),
        .i_stall     (out_stall),
        .i_cfg_we    (cfg_we),
        .i_cfg_idx   (cfg_idx),
        .i_cfg_wdata (cfg_wdata)
    );

    raycast_column_shader_checker u_checker (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_valid     (in_valid),
        .i_in        (in_data),
        .i_in_stall  (in_stall),
        .i_out_valid (out_valid),
        .i_out       (out_data),
        .i_out_stall (out_stall),
        .i_cfg_we    (cfg_we),
        .i_cfg_idx   (cfg_idx),
        .i_cfg_wdata (cfg_wdata),
        .o_errors    (errors),
        .o_pending   (pending),
        .o_checked   (checked)
    );

    always begin
        clk = 1'b1;
        #10;
        clk = 1'b0;
        #10;
    end

    always @(posedge clk) begin
        in_acc  <= in_valid && !in_stall;
        out_acc <= out_valid && !out_stall;
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall) || cfg_we) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= IDLE_LIMIT) begin
            $display("FAIL");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // Pixel sink: a fresh hold-off is drawn after every accepted pixel.
    always @(negedge clk) begin
        if (!rst_n) begin
            out_stall = 1'b0;
            out_wait  = 0;
        end else begin
            if (out_acc) out_wait = idle_mode ? $urandom_range(0, 3) : 0;
            if (out_wait > 0) begin
                out_stall = 1'b1;
                out_wait--;
            end else begin
                out_stall = 1'b0;
            end
        end
    end

    // Called and returning at a falling edge.
    task automatic send_item(input t_in_item it);
        int gap;
        gap = idle_mode ? $urandom_range(0, 3) : 0;
        if (gap > 0) begin
            in_valid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid = 1'b1;
        in_data  = it;
        if (it.kind == KIND_LOAD) loads++;
        else shades++;
        do @(negedge clk); while (!in_acc);
    endtask

    task automatic load_texel(input logic [11:0] idx, input logic [31:0] argb);
        t_in_item it;
        it             = t_in_item'({$urandom, $urandom, $urandom, $urandom});
        it.kind        = KIND_LOAD;
        it.texel_index = idx;
        it.texel_value = argb;
        send_item(it);
    endtask

    // Columns 0 to 7 of every texture row are filled first, so the hit coordinates are
    // folded into those columns while their upper bits stay as given.
    task automatic shade(input logic [23:0] ray_dist, input logic signed [11:0] ang,
                         input logic vert, input logic [15:0] hx,
                         input logic [15:0] hy, input logic [10:0] row);
        t_in_item it;
        it              = t_in_item'({$urandom, $urandom, $urandom, $urandom});
        it.kind         = KIND_SHADE;
        it.ray_distance = ray_dist;
        it.angle_offset = ang;
        it.hit_vertical = vert;
        it.hit_x        = hx & 16'hFFC7;
        it.hit_y        = hy & 16'hFFC7;
        it.row          = row;
        send_item(it);
    endtask

    task automatic random_item();
        logic [23:0]        ray_dist;
        logic signed [11:0] ang;
        logic [10:0]        row;
        int                 lim;
        if ($urandom_range(0, 4) == 0) begin
            load_texel(12'($urandom), $urandom);
        end else begin
            case ($urandom_range(0, 3))
                0: ray_dist = 24'($urandom);
                1: ray_dist = 24'($urandom_range(0, 16'hFFFF));
                2: ray_dist = 24'($urandom_range(16'h4000, 24'h4_0000));
                default: ray_dist = 24'($urandom_range(0, 8'hFF));
            endcase
            if ($urandom_range(0, 3) != 0) ang = 12'(int'($urandom_range(0, 2046)) - 1023);
            else ang = 12'($urandom);
            lim = (cur_rows > 2047) ? 2047 : int'(cur_rows);
            row = ($urandom_range(0, 1) != 0) ? 11'($urandom_range(0, lim)) : 11'($urandom);
            shade(ray_dist, ang, 1'($urandom), 16'($urandom), 16'($urandom), row);
        end
    endtask

    // Registers change only once the pipeline has drained.
    task automatic program_regs(input logic [15:0] ppd, input logic [10:0] tile,
                                input logic [11:0] rows, input logic [31:0] ceil_c,
                                input logic [31:0] floor_c);
        logic [31:0] vals [5];
        vals = '{32'(ppd), 32'(tile), 32'(rows), ceil_c, floor_c};
        in_valid = 1'b0;
        while (pending != 0) @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
        for (int i = 0; i < 5; i++) begin
            cfg_we    = 1'b1;
            cfg_idx   = CFG_IDX_W'(i);
            cfg_wdata = vals[i];
            cfg_writes++;
            @(negedge clk);
        end
        cfg_we   = 1'b0;
        cur_rows = rows;
    endtask

    initial begin
        rst_n        = 1'b0;
        in_valid     = 1'b0;
        in_data      = '0;
        cfg_we       = 1'b0;
        cfg_idx      = CFG_PROJ_PLANE_DIST;
        cfg_wdata    = '0;
        idle_mode    = 1'b0;
        quiet_cycles = 0;
        shades       = 0;
        loads        = 0;
        cfg_writes   = 0;
        cur_rows     = SCREEN_RESET;
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Fill columns 0 to 7 of every texture row first so that no wall read
        // hits an unwritten entry.
        for (int i = 0; i < FILL_TEXELS; i++) begin
            idle_mode = (i % 128) >= 64;
            load_texel(12'((i / 8) * 64 + (i % 8)), $urandom);
        end

        // Directed transactions under the reset register values.
        idle_mode = 1'b1;
        load_texel(12'hFFF, 32'hFFFF_FFFF);
        load_texel(12'h000, 32'h0000_0000);
        shade(24'd0, 12'sd0, 1'b0, 16'd0, 16'd0, 11'd0);
        shade(24'd0, 12'sd0, 1'b1, 16'hFFFF, 16'hFFFF, 11'd599);
        shade(24'hFF_FFFF, 12'sd0, 1'b0, 16'hFFFF, 16'd0, 11'd300);
        shade(24'hFF_FFFF, 12'sd0, 1'b0, 16'd5, 16'd0, 11'd0);
        shade(24'hFF_FFFF, 12'sd0, 1'b0, 16'd5, 16'd0, 11'd2047);
        shade(24'h00_4000, -12'sd2048, 1'b1, 16'd0, 16'd63, 11'd100);
        shade(24'h00_4000, 12'sd2047, 1'b0, 16'd64, 16'd0, 11'd300);
        shade(24'h00_4000, 12'sd1024, 1'b0, 16'd1, 16'd0, 11'd10);
        shade(24'h00_4000, -12'sd1024, 1'b1, 16'd0, 16'd2, 11'd590);
        shade(24'h00_4000, 12'sd1023, 1'b0, 16'd7, 16'd0, 11'd300);
        shade(24'h00_4000, -12'sd1023, 1'b0, 16'd7, 16'd0, 11'd300);
        shade(24'h01_0000, 12'sd200, 1'b1, 16'd9, 16'hAAAA, 11'd250);
        shade(24'h01_0000, -12'sd200, 1'b0, 16'h5555, 16'd9, 11'd350);
        shade(24'h00_0001, 12'sd0, 1'b0, 16'd3, 16'd0, 11'd600);
        shade(24'h00_0100, 12'sd0, 1'b0, 16'd3, 16'd0, 11'd1000);

        // Degenerate geometry: no wall at all, then a wall under two rows tall.
        program_regs(16'd0, 11'd0, 12'd2, 32'h0000_0000, 32'hFFFF_FFFF);
        shade(24'h00_1000, 12'sd0, 1'b0, 16'd0, 16'd0, 11'd0);
        shade(24'h00_1000, 12'sd0, 1'b0, 16'd0, 16'd0, 11'd1);
        shade(24'h00_1000, 12'sd0, 1'b0, 16'd0, 16'd0, 11'd2047);
        program_regs(16'd1, 11'd1, 12'd600, 32'h1234_5678, 32'h8765_4321);
        shade(24'hFF_FFFF, 12'sd0, 1'b0, 16'd0, 16'd0, 11'd299);
        shade(24'hFF_FFFF, 12'sd0, 1'b0, 16'd0, 16'd0, 11'd300);

        for (int s = 0; s < 6; s++) begin
            case (s)
                0: program_regs(16'd1, 11'd1, 12'd2, 32'hFFFF_FFFF, 32'h0000_0000);
                1: program_regs(16'hFFFF, 11'd1024, 12'd2048, 32'hAAAA_AAAA, 32'h5555_5555);
                2: program_regs(PPD_RESET, 11'd2047, 12'hFFF, $urandom, $urandom);
                3: program_regs(16'd0, TILE_RESET, 12'd479, $urandom, $urandom);
                4: program_regs(16'($urandom), 11'($urandom_range(1, 1024)),
                                12'($urandom_range(2, 2048)), $urandom, $urandom);
                default: program_regs(PPD_RESET, TILE_RESET, SCREEN_RESET,
                                      CEILING_RESET, FLOOR_RESET);
            endcase
            for (int n = 0; n < ITEMS_PER_SETTING; n++) begin
                // Alternate stretches with and without gaps and stalls.
                idle_mode = ((n / 40) % 3) != 2;
                random_item();
            end
        end

        in_valid = 1'b0;
        while (pending != 0) @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);

        $display("Covered %0d loads, %0d shades and %0d register writes over nine settings.",
                 loads, shades, cfg_writes);
        $display("Checked %0d pixels, %0d mismatches.", checked, errors);
        if (errors == 0 && pending == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
